// File: hw/rtl/bpst_pkg.sv
package bpst_pkg;

  // default parameter values
  localparam int MAX_ORDER_DEFAULT      = 1023;
  localparam int COEF_FRAC_BITS_DEFAULT = 16;

  // cordic constants: step count, inverse gain and pi in Q30, pi in Q29
  localparam int          CORDIC_STEPS    = 24;
  localparam logic [31:0] CORDIC_INV_GAIN = 32'd652032874;
  localparam logic [31:0] PI_Q30          = 32'd3373259426;
  localparam logic [30:0] PI_Q29          = 31'd1686629713;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_LOW_CUTOFF   = 2'd0,
    REG_HIGH_CUTOFF  = 2'd1,
    REG_FILTER_ORDER = 2'd2
  } cfg_reg_t;

  // per-tap side information that rides along the pipeline
  typedef struct packed {
    logic [9:0]  am;      // |2j - order|
    logic        last;
    logic        err;
    logic        center;
    logic        cneg;
    logic [16:0] cmag;    // saturated centre tap magnitude
  } tap_info_t;

  // truncated Q30 arctangent of 2^-i
  function automatic logic [30:0] atan_q30(input int i);
    logic [30:0] v;
    case (i)
      0:  v = 31'd843314856;
      1:  v = 31'd497837829;
      2:  v = 31'd263043836;
      3:  v = 31'd133525158;
      4:  v = 31'd67021686;
      5:  v = 31'd33543515;
      6:  v = 31'd16775850;
      7:  v = 31'd8388437;
      8:  v = 31'd4194282;
      9:  v = 31'd2097149;
      10: v = 31'd1048575;
      11: v = 31'd524287;
      12: v = 31'd262143;
      13: v = 31'd131071;
      14: v = 31'd65535;
      15: v = 31'd32767;
      16: v = 31'd16383;
      17: v = 31'd8191;
      18: v = 31'd4095;
      19: v = 31'd2047;
      20: v = 31'd1023;
      21: v = 31'd511;
      22: v = 31'd255;
      23: v = 31'd127;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/bandpass_sinc_tap_generator.sv
// throughput: one tap per cycle unless the output stalls, set by the fully pipelined
//   cordic (one stage per step) and the restoring divider (one quotient bit per stage)
// a stalled output freezes the whole pipeline; bubbles travel as cleared valid bits
// synchronous reset clears all valid bits and the cutoff and order registers to zero
module bandpass_sinc_tap_generator #(
  parameter int MAX_ORDER      = bpst_pkg::MAX_ORDER_DEFAULT,
  parameter int COEF_FRAC_BITS = bpst_pkg::COEF_FRAC_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [9:0]         tap_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] coefficient,
  output logic               last_tap,
  output logic               index_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int F      = COEF_FRAC_BITS;
  localparam int QW     = F + 1;
  localparam int NC     = bpst_pkg::CORDIC_STEPS;
  localparam int CW     = 33;
  localparam int LIMIT  = (F >= 17) ? 131071 : (1 << F);
  localparam int CFW    = F + 18;
  localparam int DENW   = 41;
  localparam int ADW    = 33;
  localparam int RW     = 42 + F;
  localparam int S_E    = 4;
  localparam int S_F    = S_E + NC + 1;
  localparam int S_G    = S_F + 1;
  localparam int S_OUT  = S_G + QW + 1;

  logic [15:0] low_cutoff;
  logic [15:0] high_cutoff;
  logic [9:0]  filter_order;

  logic                    en;
  logic                    vld  [0:S_OUT];
  bpst_pkg::tap_info_t     side [0:S_OUT];

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_cutoff   <= '0;
      high_cutoff  <= '0;
      filter_order <= '0;
    end else if (cfg_valid) begin
      unique case (bpst_pkg::cfg_reg_t'(cfg_index))
        bpst_pkg::REG_LOW_CUTOFF:   low_cutoff   <= cfg_data;
        bpst_pkg::REG_HIGH_CUTOFF:  high_cutoff  <= cfg_data;
        bpst_pkg::REG_FILTER_ORDER: filter_order <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: only a held result at the output stalls it
  assign en        = !vld[S_OUT] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[S_OUT];

  // stage a: index checks, |m| and centre tap
  logic [9:0]         order_c;
  logic signed [11:0] m_diff;
  logic [11:0]        m_abs;
  logic               c_neg;
  logic [15:0]        c_abs;
  logic [CFW-1:0]     c_full;
  bpst_pkg::tap_info_t info_a;

  always_comb begin
    order_c = (32'(filter_order) > MAX_ORDER) ? 10'(MAX_ORDER) : filter_order;
    m_diff  = $signed({1'b0, tap_index, 1'b0}) - $signed({2'b00, order_c});
    m_abs   = m_diff[11] ? 12'(-m_diff) : 12'(m_diff);
    c_neg   = high_cutoff < low_cutoff;
    c_abs   = c_neg ? (low_cutoff - high_cutoff) : (high_cutoff - low_cutoff);
    c_full  = ((CFW'(c_abs) << (F + 1)) + CFW'(32768)) >> 16;
    info_a.am     = m_abs[9:0];
    info_a.last   = tap_index == order_c;
    info_a.err    = tap_index > order_c;
    info_a.center = m_abs == 12'd0;
    info_a.cneg   = c_neg;
    info_a.cmag   = (c_full > CFW'(LIMIT)) ? 17'(LIMIT) : 17'(c_full);
  end

  // valid bits and side information shift along every stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= S_OUT; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 1; s <= S_OUT; s++) vld[s] <= vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= info_a;
      for (int s = 1; s <= S_OUT; s++) side[s] <= side[s-1];
    end
  end

  // lane 0 carries the high cutoff, lane 1 the low cutoff
  logic [16:0]          ph    [0:1];
  logic [15:0]          amag  [0:1];
  logic                 aneg  [0:1];
  logic [47:0]          aprod [0:1];
  logic                 pneg  [0:1];
  logic signed [CW-1:0] cx    [0:1][0:NC];
  logic signed [CW-1:0] cy    [0:1][0:NC];
  logic signed [CW-1:0] cz    [0:1][0:NC];

  function automatic logic [16:0] fold_phase(input logic [16:0] p);
    logic [16:0] r;
    if (p <= 17'd32768) begin
      r = {1'b0, p[15:0]};
    end else if (p < 17'd98304) begin
      if (p > 17'd65536) r = {1'b1, 16'(p - 17'd65536)};
      else               r = {1'b0, 16'(17'd65536 - p)};
    end else begin
      r = {1'b1, 16'(18'd131072 - {1'b0, p})};
    end
    return r;
  endfunction

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    logic [15:0] cut;
    logic [25:0] ph_full;
    logic [16:0] folded;
    logic [31:0] zmag;

    assign cut     = (ln == 0) ? high_cutoff : low_cutoff;
    assign ph_full = cut * side[0].am;
    assign folded  = fold_phase(ph[ln]);
    assign zmag    = aprod[ln][47:16];

    // stage b: phase, stage c: fold, stage d: scale to radians, stage e: cordic seed
    always_ff @(posedge clk) begin
      if (en) begin
        ph[ln]    <= ph_full[16:0];
        amag[ln]  <= folded[15:0];
        aneg[ln]  <= folded[16];
        aprod[ln] <= amag[ln] * bpst_pkg::PI_Q30;
        pneg[ln]  <= aneg[ln];
        cx[ln][0] <= $signed({1'b0, bpst_pkg::CORDIC_INV_GAIN});
        cy[ln][0] <= '0;
        cz[ln][0] <= pneg[ln] ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
      end
    end

    // cordic rotation, one step per stage
    for (genvar i = 0; i < NC; i++) begin : g_step
      logic signed [CW-1:0] ang;
      assign ang = $signed({2'b00, bpst_pkg::atan_q30(i)});

      always_ff @(posedge clk) begin
        if (en) begin
          if (!cz[ln][i][CW-1]) begin
            cx[ln][i+1] <= cx[ln][i] - (cy[ln][i] >>> i);
            cy[ln][i+1] <= cy[ln][i] + (cx[ln][i] >>> i);
            cz[ln][i+1] <= cz[ln][i] - ang;
          end else begin
            cx[ln][i+1] <= cx[ln][i] + (cy[ln][i] >>> i);
            cy[ln][i+1] <= cy[ln][i] - (cx[ln][i] >>> i);
            cz[ln][i+1] <= cz[ln][i] + ang;
          end
        end
      end
    end
  end

  // stage f: sine difference and denominator
  logic signed [CW:0] d_diff;
  logic [DENW-1:0]    den_full;
  logic [ADW-1:0]     ad_f;
  logic [DENW-1:0]    den_f;
  logic               neg_f;

  assign d_diff   = $signed({cy[0][NC][CW-1], cy[0][NC]})
                  - $signed({cy[1][NC][CW-1], cy[1][NC]});
  assign den_full = DENW'(bpst_pkg::PI_Q29) * DENW'(side[S_F-1].am);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_f <= d_diff[CW];
      ad_f  <= d_diff[CW] ? ADW'(-d_diff) : ADW'(d_diff);
      den_f <= den_full;
    end
  end

  // stage g and divide stages: restoring division, one quotient bit per stage
  logic [RW-1:0]   rem  [0:QW];
  logic [QW-1:0]   quo  [0:QW];
  logic [DENW-1:0] dden [0:QW];
  logic            dneg [0:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= (RW'(ad_f) << F) + RW'(den_f >> 1);
      quo[0]  <= '0;
      dden[0] <= den_f;
      dneg[0] <= neg_f;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [RW-1:0] shd;
    assign shd = RW'(dden[k-1]) << (QW - k);

    always_ff @(posedge clk) begin
      if (en) begin
        dden[k] <= dden[k-1];
        dneg[k] <= dneg[k-1];
        if (rem[k-1] >= shd) begin
          rem[k] <= rem[k-1] - shd;
          quo[k] <= quo[k-1] | (QW'(1) << (QW - k));
        end else begin
          rem[k] <= rem[k-1];
          quo[k] <= quo[k-1];
        end
      end
    end
  end

  // output stage: select, saturate, apply sign
  logic [16:0] mag_out;
  logic        neg_out;

  always_comb begin
    bpst_pkg::tap_info_t si;
    si = side[S_OUT-1];
    if (si.err) begin
      mag_out = '0;
      neg_out = 1'b0;
    end else if (si.center) begin
      mag_out = si.cmag;
      neg_out = si.cneg;
    end else begin
      mag_out = (quo[QW] > QW'(LIMIT)) ? 17'(LIMIT) : 17'(quo[QW]);
      neg_out = dneg[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coefficient <= neg_out ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
    end
  end

  assign last_tap    = side[S_OUT].last;
  assign index_error = side[S_OUT].err;

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> coefficient == '0)
    else $error("index error with nonzero coefficient");

  a_err_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(last_tap && index_error))
    else $error("last tap and index error together");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(coefficient) <= $signed(18'(LIMIT)))
               && ($signed(coefficient) >= -$signed(18'(LIMIT))))
    else $error("coefficient beyond saturation limit");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    vld[S_G] && !en |=> vld[S_G])
    else $error("valid item lost during stall");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready disagrees with output stall");

endmodule
